// File: rtl/rct_pkg.sv
package rct_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int MAP_BITS_DEF = 32;
    localparam int COPY_LIMIT   = 32;

    localparam int FILE_ID_W = 32;
    localparam int IO_ID_W   = 32;
    localparam int SECTOR_W  = 64;
    localparam int COUNT_W   = 6;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 4;
    localparam int OFFSET_W  = 5;
    localparam int LENGTH_W  = 6;

    typedef enum logic [STATUS_W-1:0] {
        ST_ISSUED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_NOMATCH = 3'd2,
        ST_PARTIAL = 3'd3,
        ST_DONE    = 3'd4
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture accepted item, restart scan
        logic step;     // read next slot
        logic issue;    // write new entry at evaluated slot
        logic capture;  // latch offset of matched slot
        logic update;   // merge map, finish reply
        logic miss;     // scan ended without a hit
        logic emit;     // move result to output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op;       // captured op
        logic hit;      // evaluated slot fits
        logic last;     // evaluated slot is the final one
    } t_sts;

endpackage

// File: rtl/rct_if.sv
interface rct_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic        is_write;
    logic [31:0] file_id;
    logic [31:0] io_id;
    logic [63:0] start_sector;
    logic [5:0]  sector_count;

    modport source (output valid, op, is_write, file_id, io_id, start_sector, sector_count,
                    input ready);
    modport sink   (input valid, op, is_write, file_id, io_id, start_sector, sector_count,
                    output ready);
endinterface

interface rct_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] assigned_id;
    logic [3:0]  slot;
    logic [4:0]  copy_offset;
    logic [5:0]  copy_length;
    logic        overrun;

    modport source (output valid, status, assigned_id, slot, copy_offset, copy_length, overrun,
                    input ready);
    modport sink   (input valid, status, assigned_id, slot, copy_offset, copy_length, overrun,
                    output ready);
endinterface

// File: rtl/read_completion_tracker.sv
// Read completion tracker.
// i_req carries issue items (op 0: read or write request, start, count) and
// read reply items (op 1: file id, io id, start, count). o_rsp carries one
// result per item: status, assigned or matched id, slot, clipped copy
// offset and length, and the overrun flag. Both channels move an item when
// valid and ready are high at a rising edge.
// Issue takes the lowest free slot and hands out the next id (1 after
// reset, wrapping). A reply is matched against valid read entries, lowest
// slot first; returned sectors are marked in the slot's completion map and
// the slot frees once every requested sector is in.
// Timing: the controller walks the slots one per cycle through the entry
// store's single read port; the scan runs to the hit slot or to the last
// slot. An issue or a miss then finishes, while a matched reply first
// goes through an update step that merges the map.
// A new item is taken only while the controller is idle; a finished result
// waits in a result register until the output register is free, so one
// result can sit on o_rsp while the next item is being worked.
// Reset clears the slot valid bits and both valid flags and sets the id counter to 1;
// entry storage needs no clearing since it is read only while valid.
module read_completion_tracker #(
    parameter int SLOTS    = rct_pkg::SLOTS_DEF,
    parameter int MAP_BITS = rct_pkg::MAP_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rct_req_if.sink    i_req,
    rct_rsp_if.source  o_rsp
);
    import rct_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencing: scan, update, result handoff
    rct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // slot table, compare and map arithmetic, result registers
    rct_dp #(
        .SLOTS    (SLOTS),
        .MAP_BITS (MAP_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_op           (i_req.op),
        .i_is_write     (i_req.is_write),
        .i_file_id      (i_req.file_id),
        .i_io_id        (i_req.io_id),
        .i_start_sector (i_req.start_sector),
        .i_sector_count (i_req.sector_count),
        .o_status       (o_rsp.status),
        .o_assigned_id  (o_rsp.assigned_id),
        .o_slot         (o_rsp.slot),
        .o_copy_offset  (o_rsp.copy_offset),
        .o_copy_length  (o_rsp.copy_length),
        .o_overrun      (o_rsp.overrun)
    );
endmodule

// File: rtl/rct_ctrl.sv
module rct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  rct_pkg::t_sts i_sts,
    output rct_pkg::t_cmd o_cmd
);
    import rct_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_UPD  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit && !i_sts.op) begin
                    o_cmd.issue = 1'b1;
                    n_state     = S_FIN;
                end else if (i_sts.hit) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPD;
                end else if (i_sts.last) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready)
            n_out_valid = 1'b0;
        if (o_cmd.emit)
            n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // a pending result is never overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !i_out_ready) |=> (r_state == S_FIN && r_out_valid))
        else $error("result overwritten while stalled");

    // every accepted item starts a scan
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SCAN))
        else $error("accept did not start scan");

    // replies go through the update step before finishing
    a_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_state == S_FIN && $past(i_sts.op)))
        else $error("update step out of order");
endmodule

// File: rtl/rct_dp.sv
module rct_dp #(
    parameter int SLOTS    = rct_pkg::SLOTS_DEF,
    parameter int MAP_BITS = rct_pkg::MAP_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rct_pkg::t_cmd i_cmd,
    output rct_pkg::t_sts o_sts,
    input  logic          i_op,
    input  logic          i_is_write,
    input  logic [31:0]   i_file_id,
    input  logic [31:0]   i_io_id,
    input  logic [63:0]   i_start_sector,
    input  logic [5:0]    i_sector_count,
    output logic [2:0]    o_status,
    output logic [31:0]   o_assigned_id,
    output logic [3:0]    o_slot,
    output logic [4:0]    o_copy_offset,
    output logic [5:0]    o_copy_length,
    output logic          o_overrun
);
    import rct_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(MAP_BITS + 1);
    localparam int OW = $clog2(MAP_BITS);
    localparam int EW = ((OW > COUNT_W) ? OW : COUNT_W) + 1;

    // captured item
    logic                r_op, r_wr;
    logic [31:0]         r_fid, r_iid;
    logic [63:0]         r_start;
    logic [COUNT_W-1:0]  r_cnt;

    logic [SLOTS-1:0]    r_valid;
    logic [31:0]         r_next_id;
    logic [SW:0]         r_idx;

    // entry store
    logic                m_wr    [SLOTS];
    logic [31:0]         m_id    [SLOTS];
    logic [63:0]         m_start [SLOTS];
    logic [CW-1:0]       m_count [SLOTS];
    logic [MAP_BITS-1:0] m_map   [SLOTS];

    logic                r_rd_ok, r_rd_wr;
    logic [SW-1:0]       r_rd_idx;
    logic [31:0]         r_rd_id;
    logic [63:0]         r_rd_start;
    logic [CW-1:0]       r_rd_count;
    logic [MAP_BITS-1:0] r_rd_map;

    logic [OW-1:0]       r_off;

    // result and output registers
    t_status             r_res_st, r_o_st;
    logic [31:0]         r_res_id, r_o_id;
    logic [SW-1:0]       r_res_slot, r_o_slot;
    logic [OW-1:0]       r_res_off, r_o_off;
    logic [LENGTH_W-1:0] r_res_len, r_o_len;
    logic                r_res_ovr, r_o_ovr;

    logic [64:0]         w_diff;
    logic                w_in_range, w_match;
    logic [CW-1:0]       w_cnt_sat;
    logic [EW-1:0]       w_end, w_end_c, w_len, w_count_e;
    logic                w_ovr;
    logic [MAP_BITS-1:0] w_low, w_need, w_map;
    logic                w_all;
    logic [63:0]         w_off_ext;
    logic [15:0]         w_slot_ext;

    // slot evaluation
    assign w_diff     = {1'b0, r_start} - {1'b0, r_rd_start};
    assign w_in_range = !w_diff[64] && (w_diff[63:0] < 64'(r_rd_count));
    assign w_match    = r_valid[r_rd_idx] && !r_rd_wr && (r_fid == '0) &&
                        (r_rd_id == r_iid) && w_in_range;

    assign o_sts.op   = r_op;
    assign o_sts.hit  = r_rd_ok && (r_op ? w_match : !r_valid[r_rd_idx]);
    assign o_sts.last = r_rd_ok && (r_rd_idx == SW'(SLOTS - 1));

    assign w_cnt_sat  = (EW'(r_cnt) > EW'(MAP_BITS)) ? CW'(MAP_BITS) : CW'(r_cnt);

    // reply arithmetic on the matched slot
    assign w_count_e = EW'(r_rd_count);
    assign w_end     = EW'(r_off) + EW'(r_cnt);
    assign w_ovr     = (w_end > w_count_e);
    assign w_end_c   = w_ovr ? w_count_e : w_end;
    assign w_len     = w_end_c - EW'(r_off);
    // shift by MAP_BITS or more wraps to all ones
    assign w_low     = (MAP_BITS'(1) << r_cnt) - MAP_BITS'(1);
    assign w_need    = (MAP_BITS'(1) << r_rd_count) - MAP_BITS'(1);
    assign w_map     = r_rd_map | (w_low << r_off);
    assign w_all     = ((w_map & w_need) == w_need);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_wr    <= i_is_write;
            r_fid   <= i_file_id;
            r_iid   <= i_io_id;
            r_start <= i_start_sector;
            r_cnt   <= i_sector_count;
        end
        if (i_cmd.step) begin
            r_rd_idx   <= r_idx[SW-1:0];
            r_rd_wr    <= m_wr[r_idx[SW-1:0]];
            r_rd_id    <= m_id[r_idx[SW-1:0]];
            r_rd_start <= m_start[r_idx[SW-1:0]];
            r_rd_count <= m_count[r_idx[SW-1:0]];
            r_rd_map   <= m_map[r_idx[SW-1:0]];
        end
        if (i_cmd.issue) begin
            m_wr[r_rd_idx]    <= r_wr;
            m_id[r_rd_idx]    <= r_next_id;
            m_start[r_rd_idx] <= r_start;
            m_count[r_rd_idx] <= w_cnt_sat;
            m_map[r_rd_idx]   <= '0;
        end
        if (i_cmd.update)
            m_map[r_rd_idx] <= w_map;
        if (i_cmd.capture)
            r_off <= w_diff[OW-1:0];

        if (i_cmd.issue) begin
            r_res_st   <= ST_ISSUED;
            r_res_id   <= r_next_id;
            r_res_slot <= r_rd_idx;
            r_res_off  <= '0;
            r_res_len  <= '0;
            r_res_ovr  <= 1'b0;
        end
        if (i_cmd.miss) begin
            r_res_st   <= r_op ? ST_NOMATCH : ST_FULL;
            r_res_id   <= '0;
            r_res_slot <= '0;
            r_res_off  <= '0;
            r_res_len  <= '0;
            r_res_ovr  <= 1'b0;
        end
        if (i_cmd.update) begin
            r_res_st   <= w_all ? ST_DONE : ST_PARTIAL;
            r_res_id   <= r_rd_id;
            r_res_slot <= r_rd_idx;
            r_res_off  <= r_off;
            r_res_len  <= (w_len > EW'(COPY_LIMIT)) ? '0 : w_len[LENGTH_W-1:0];
            r_res_ovr  <= w_ovr;
        end
        if (i_cmd.emit) begin
            r_o_st   <= r_res_st;
            r_o_id   <= r_res_id;
            r_o_slot <= r_res_slot;
            r_o_off  <= r_res_off;
            r_o_len  <= r_res_len;
            r_o_ovr  <= r_res_ovr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_next_id <= 32'd1;
            r_idx     <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_rd_ok <= 1'b0;
            end else if (i_cmd.step) begin
                r_idx   <= r_idx + (SW+1)'(1);
                r_rd_ok <= (r_idx < (SW+1)'(SLOTS));
            end
            if (i_cmd.issue) begin
                r_valid[r_rd_idx] <= 1'b1;
                r_next_id         <= r_next_id + 32'd1;
            end
            if (i_cmd.update && w_all)
                r_valid[r_rd_idx] <= 1'b0;
        end
    end

    assign w_off_ext     = 64'(r_o_off);
    assign w_slot_ext    = 16'(r_o_slot);
    assign o_status      = r_o_st;
    assign o_assigned_id = r_o_id;
    assign o_slot        = w_slot_ext[3:0];
    assign o_copy_offset = w_off_ext[4:0];
    assign o_copy_length = r_o_len;
    assign o_overrun     = r_o_ovr;

    // a new entry only lands in a free slot
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> !r_valid[r_rd_idx])
        else $error("issue into occupied slot");

    // a matched offset always lies inside the request
    a_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> (EW'(r_off) < w_count_e))
        else $error("offset outside request");

    // id counter advances exactly on issue
    a_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.issue |=> $stable(r_next_id))
        else $error("id counter moved without issue");
endmodule
